// File: hw/rtl/mpmq_pkg.sv
// ----------------------------------------------------------------------------
// Multi-port mailbox queue package
// Shared sizes, opcodes, status codes and the controller command struct.
// ----------------------------------------------------------------------------
package mpmq_pkg;

   // Sizing
   localparam int PORT_COUNT   = 16;
   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam int PORT_W    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W    = PORT_W + PTR_W;
   localparam int MEM_DEPTH = PORT_COUNT * (2 ** PTR_W);
   localparam int MSG_W     = 32 + PAYLOAD_BITS;

   localparam logic [15:0]      PORT_LIMIT = 16'(PORT_COUNT);
   localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);

   // Opcodes
   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_RECEIVE = 2'd1;
   localparam logic [1:0] OP_NOTIFY  = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_PORT  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_WAITING   = 3'd3;
   localparam logic [2:0] ST_NO_CALLER = 3'd4;
   localparam logic [2:0] ST_NO_WAITER = 3'd5;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, sample waiter match vector
      logic execute;   // update port state, issue store access
      logic load_out;  // load response register
   } mpmq_cmd_type;

endpackage

// File: hw/rtl/mpmq_req_if.sv
// ----------------------------------------------------------------------------
// Mailbox request channel
// Valid/ready channel carrying one mailbox command transaction.
// ----------------------------------------------------------------------------
interface mpmq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] port_index;
   logic [15:0] proc_id;
   logic        caller_present;
   logic [15:0] msg_sender;
   logic [15:0] msg_kind;
   logic [31:0] msg_payload;

   modport source (
      output valid, opcode, port_index, proc_id, caller_present,
             msg_sender, msg_kind, msg_payload,
      input  ready
   );
   modport sink (
      input  valid, opcode, port_index, proc_id, caller_present,
             msg_sender, msg_kind, msg_payload,
      output ready
   );
endinterface

// File: hw/rtl/mpmq_rsp_if.sv
// ----------------------------------------------------------------------------
// Mailbox response channel
// Valid/ready channel carrying one status and dequeued message transaction.
// ----------------------------------------------------------------------------
interface mpmq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        out_valid;
   logic [15:0] out_sender;
   logic [15:0] out_kind;
   logic [31:0] out_payload;

   modport source (
      output valid, status, out_valid, out_sender, out_kind, out_payload,
      input  ready
   );
   modport sink (
      input  valid, status, out_valid, out_sender, out_kind, out_payload,
      output ready
   );
endinterface

// File: hw/rtl/mpmq_datapath.sv
// ----------------------------------------------------------------------------
// Mailbox datapath
// Request registers, per-port ring state, waiter marks, message store and
// the response register.
// ----------------------------------------------------------------------------
module mpmq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mpmq_pkg::mpmq_cmd_type cmd,
   input  logic [1:0]            req_opcode,
   input  logic [15:0]           req_port_index,
   input  logic [15:0]           req_proc_id,
   input  logic                  req_caller_present,
   input  logic [15:0]           req_msg_sender,
   input  logic [15:0]           req_msg_kind,
   input  logic [31:0]           req_msg_payload,
   output logic [2:0]            rsp_status,
   output logic                  rsp_out_valid,
   output logic [15:0]           rsp_out_sender,
   output logic [15:0]           rsp_out_kind,
   output logic [31:0]           rsp_out_payload
);

   localparam int PC  = mpmq_pkg::PORT_COUNT;
   localparam int PW  = mpmq_pkg::PORT_W;
   localparam int TW  = mpmq_pkg::PTR_W;
   localparam int CW  = mpmq_pkg::CNT_W;
   localparam int AW  = mpmq_pkg::ADDR_W;
   localparam int PB  = mpmq_pkg::PAYLOAD_BITS;
   localparam int MW  = mpmq_pkg::MSG_W;

   // Latched request
   logic [1:0]    op_ff;
   logic [15:0]   port_ff;
   logic [15:0]   pid_ff;
   logic          caller_ff;
   logic [15:0]   sender_ff;
   logic [15:0]   kind_ff;
   logic [PB-1:0] payload_ff;
   logic [PC-1:0] match_ff;

   // Per-port state
   logic [TW-1:0] head_ff   [PC];
   logic [TW-1:0] tail_ff   [PC];
   logic [CW-1:0] count_ff  [PC];
   logic          wvalid_ff [PC];
   logic [15:0]   wid_ff    [PC];

   // Message store
   logic [MW-1:0] mem [mpmq_pkg::MEM_DEPTH];
   logic [MW-1:0] rdata_ff;

   // Execute results
   logic [2:0]    status_ff, status_in;
   logic          deq_ff, deq_in;

   // Response register
   logic [2:0]    out_status_ff;
   logic          out_valid_ff;
   logic [15:0]   out_sender_ff;
   logic [15:0]   out_kind_ff;
   logic [31:0]   out_payload_ff;

   // Execute-stage decode
   logic [PW-1:0] notify_port;
   logic [PW-1:0] sel_port;
   logic          port_ok;
   logic          found;
   logic          is_full;
   logic          push, pop, clr_waiter, set_waiter;
   logic [MW-1:0] wr_msg;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [TW-1:0] head_next, tail_next;

   // Capture request and sample the waiter match vector
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_opcode;
         port_ff    <= req_port_index;
         pid_ff     <= req_proc_id;
         caller_ff  <= req_caller_present;
         sender_ff  <= req_msg_sender;
         kind_ff    <= req_msg_kind;
         payload_ff <= req_msg_payload[PB-1:0];
         for (int i = 0; i < PC; i++) begin
            match_ff[i] <= wvalid_ff[i] && (wid_ff[i] == req_proc_id);
         end
      end
   end

   // Pick the lowest matching waiter port
   always_comb begin
      notify_port = '0;
      for (int i = PC - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            notify_port = PW'(i);
         end
      end
   end

   assign found    = |match_ff;
   assign port_ok  = port_ff < mpmq_pkg::PORT_LIMIT;
   assign sel_port = (op_ff == mpmq_pkg::OP_NOTIFY) ? notify_port : port_ff[PW-1:0];
   assign is_full  = count_ff[sel_port] >= mpmq_pkg::QUEUE_FULL;

   assign head_next = (head_ff[sel_port] == mpmq_pkg::PTR_LAST) ? '0
                    : head_ff[sel_port] + 1'b1;
   assign tail_next = (tail_ff[sel_port] == mpmq_pkg::PTR_LAST) ? '0
                    : tail_ff[sel_port] + 1'b1;
   assign wr_addr   = {sel_port, tail_ff[sel_port]};
   assign rd_addr   = {sel_port, head_ff[sel_port]};

   // Decide the operation outcome
   always_comb begin
      status_in  = mpmq_pkg::ST_BAD_PORT;
      deq_in     = 1'b0;
      push       = 1'b0;
      pop        = 1'b0;
      clr_waiter = 1'b0;
      set_waiter = 1'b0;
      wr_msg     = {sender_ff, kind_ff, payload_ff};
      unique case (op_ff)
         mpmq_pkg::OP_SEND: begin
            if (port_ok) begin
               clr_waiter = 1'b1;
               if (is_full) begin
                  status_in = mpmq_pkg::ST_FULL;
               end else begin
                  push      = 1'b1;
                  status_in = mpmq_pkg::ST_OK;
               end
            end
         end
         mpmq_pkg::OP_RECEIVE: begin
            if (port_ok) begin
               if (count_ff[sel_port] != '0) begin
                  pop       = 1'b1;
                  deq_in    = 1'b1;
                  status_in = mpmq_pkg::ST_OK;
               end else if (caller_ff) begin
                  set_waiter = 1'b1;
                  status_in  = mpmq_pkg::ST_WAITING;
               end else begin
                  status_in = mpmq_pkg::ST_NO_CALLER;
               end
            end
         end
         mpmq_pkg::OP_NOTIFY: begin
            wr_msg = {16'h0000, kind_ff, {PB{1'b0}}};
            if (!found) begin
               status_in = mpmq_pkg::ST_NO_WAITER;
            end else begin
               clr_waiter = 1'b1;
               if (is_full) begin
                  status_in = mpmq_pkg::ST_FULL;
               end else begin
                  push      = 1'b1;
                  status_in = mpmq_pkg::ST_OK;
               end
            end
         end
         default: begin
            status_in = mpmq_pkg::ST_BAD_PORT;
         end
      endcase
   end

   // Update per-port ring pointers, fill counts and waiter marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PC; i++) begin
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            count_ff[i]  <= '0;
            wvalid_ff[i] <= 1'b0;
            wid_ff[i]    <= '0;
         end
      end else if (cmd.execute) begin
         if (push) begin
            tail_ff[sel_port]  <= tail_next;
            count_ff[sel_port] <= count_ff[sel_port] + 1'b1;
         end else if (pop) begin
            head_ff[sel_port]  <= head_next;
            count_ff[sel_port] <= count_ff[sel_port] - 1'b1;
         end
         if (clr_waiter) begin
            wvalid_ff[sel_port] <= 1'b0;
         end
         if (set_waiter) begin
            wvalid_ff[sel_port] <= 1'b1;
            wid_ff[sel_port]    <= pid_ff;
         end
      end
   end

   // Message store: one write or one registered read per execute
   always_ff @(posedge clock) begin
      if (cmd.execute && push) begin
         mem[wr_addr] <= wr_msg;
      end
      if (cmd.execute && pop) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Hold the execute outcome until the response is loaded
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         deq_ff    <= deq_in;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff  <= status_ff;
         out_valid_ff   <= deq_ff;
         out_sender_ff  <= deq_ff ? rdata_ff[MW-1 -: 16] : 16'h0000;
         out_kind_ff    <= deq_ff ? rdata_ff[MW-17 -: 16] : 16'h0000;
         out_payload_ff <= deq_ff ? 32'(rdata_ff[PB-1:0]) : 32'h0000_0000;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_out_sender  = out_sender_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_payload = out_payload_ff;

endmodule

// File: hw/rtl/mpmq_controller.sv
// ----------------------------------------------------------------------------
// Mailbox controller
// Sequences capture, execute and response load, and owns the handshakes.
// ----------------------------------------------------------------------------
module mpmq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mpmq_pkg::mpmq_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Hold off new transactions while reset is applied
      if (reset) begin
         req_ready   = 1'b0;
         cmd.capture = 1'b0;
      end
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> $past(cmd.capture))
      else $error("execute without a captured transaction");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> !req_ready)
      else $error("request accepted while executing");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded response not presented");

endmodule

// File: hw/rtl/multi_port_mailbox_queue.sv
// Sequence: an accepted request is captured, executed and loaded into the
//   response register, which presents it; the load waits while the last response is untaken.
// Overlap: the next request is taken as a response loads, never during execute.
// Reset: synchronous; clears ring pointers, fill counts and waiter marks. The
//   message store is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
// Multi-port mailbox queue
// Per-port ring FIFOs with waiting-receiver marks; send, receive and notify.
// ----------------------------------------------------------------------------
module multi_port_mailbox_queue (
   input  logic        clock,
   input  logic        reset,
   mpmq_req_if.sink    req,
   mpmq_rsp_if.source  rsp
);

   mpmq_pkg::mpmq_cmd_type cmd;
   logic                   ctl_req_ready;
   logic                   ctl_rsp_valid;

   // Sequencing and handshakes
   mpmq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctl_req_ready),
      .rsp_valid (ctl_rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // Queue state and message store
   mpmq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req.opcode),
      .req_port_index     (req.port_index),
      .req_proc_id        (req.proc_id),
      .req_caller_present (req.caller_present),
      .req_msg_sender     (req.msg_sender),
      .req_msg_kind       (req.msg_kind),
      .req_msg_payload    (req.msg_payload),
      .rsp_status         (rsp.status),
      .rsp_out_valid      (rsp.out_valid),
      .rsp_out_sender     (rsp.out_sender),
      .rsp_out_kind       (rsp.out_kind),
      .rsp_out_payload    (rsp.out_payload)
   );

   assign req.ready = ctl_req_ready;
   assign rsp.valid = ctl_rsp_valid;

endmodule
